// ===== hdl/brir_pkg.sv =====
// Package for the bilinear image resampler: payload types, register indexes,
// fixed widths and the per-axis position mapping. No dependencies.

package brir_pkg;

  // Field and arithmetic widths fixed by the interface.
  localparam int SIZE_W    = 9;              // source size and source coordinate
  localparam int DSIZE_W   = 13;             // destination size register
  localparam int DCOORD_W  = 12;             // destination coordinate
  localparam int FRAC_W    = 16;             // Q16 fraction
  localparam int PROD_W    = 22;             // (2d+1) * S
  localparam int QUO_W     = PROD_W + FRAC_W; // quotient bits, one divider stage each
  localparam int DIV_W     = 14;             // 2 * D
  localparam int REM_W     = 14;
  localparam int TOP_W     = 24;             // horizontal blend, Q16
  localparam int ACC_W     = 40;             // vertical blend, Q32
  localparam int CH_CNT_W  = 3;
  localparam int DST_MAX   = 4096;
  localparam int HALF_Q16  = 32768;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Credits for requests between the pixel store and the output register.
  localparam int INFL_W = 2;
  localparam logic [INFL_W-1:0] MAX_INFL = 2'd3;

  typedef struct packed {
    logic                op;
    logic [7:0]          src_col;
    logic [7:0]          src_row;
    logic [DCOORD_W-1:0] dst_col;
    logic [DCOORD_W-1:0] dst_row;
    logic [7:0]          in_chan0;
    logic [7:0]          in_chan1;
    logic [7:0]          in_chan2;
    logic [7:0]          in_chan3;
  } req_t;

  typedef struct packed {
    logic [DCOORD_W-1:0] res_col;
    logic [DCOORD_W-1:0] res_row;
    logic [7:0]          out_chan0;
    logic [7:0]          out_chan1;
    logic [7:0]          out_chan2;
    logic [7:0]          out_chan3;
  } res_t;

  // Neighbours and weight along one axis.
  typedef struct packed {
    logic [SIZE_W-1:0] n0;
    logic [SIZE_W-1:0] n1;
    logic [FRAC_W-1:0] w;
  } axis_map_t;

  // Control handed from the store sequencer to the blend pipeline.
  typedef struct packed {
    logic                load;
    logic [FRAC_W-1:0]   wx;
    logic [FRAC_W-1:0]   wy;
    logic [DCOORD_W-1:0] col;
    logic [DCOORD_W-1:0] row;
  } blend_req_t;

  // Turns the Q16 quotient into neighbours and weight, clamped to the edge.
  function automatic axis_map_t map_axis(input logic [QUO_W-1:0] q,
                                         input logic [SIZE_W-1:0] s);
    logic [QUO_W-1:0]        pos;
    logic [QUO_W-FRAC_W-1:0] ip;
    logic [SIZE_W-1:0]       last;
    axis_map_t               m;
    pos  = (q >= QUO_W'(HALF_Q16)) ? q - QUO_W'(HALF_Q16) : '0;
    ip   = pos[QUO_W-1:FRAC_W];
    last = s - 9'd1;
    m.n0 = (ip > {{(QUO_W-FRAC_W-SIZE_W){1'b0}}, last}) ? last : ip[SIZE_W-1:0];
    m.n1 = (m.n0 == last) ? last : m.n0 + 9'd1;
    m.w  = pos[FRAC_W-1:0];
    return m;
  endfunction

endpackage

// ===== hdl/brir_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.

module brir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One access per cycle: write, or read with the data registered for the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/brir_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the Q16
// source position of one axis. Depends on brir_pkg.

module brir_div_pipe
  import brir_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [PROD_W-1:0] prod,
  input  logic [DIV_W-1:0]  divisor,
  output logic [QUO_W-1:0]  quo
);

  logic [REM_W-1:0]  rem_s  [1:QUO_W];
  logic [QUO_W-1:0]  quo_s  [1:QUO_W];
  logic [PROD_W-1:0] prod_s [1:QUO_W];

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [REM_W-1:0]  rp;
    logic [QUO_W-1:0]  qp;
    logic [PROD_W-1:0] pp;
    logic              nb;
    logic [REM_W:0]    t;
    logic              ge;

    if (k == 1) begin : g_first
      assign rp = '0;
      assign qp = '0;
      assign pp = prod;
    end else begin : g_next
      assign rp = rem_s[k-1];
      assign qp = quo_s[k-1];
      assign pp = prod_s[k-1];
    end

    // The numerator is the product shifted up by the fraction width.
    if (QUO_W - k >= FRAC_W) begin : g_bit
      assign nb = pp[QUO_W-k-FRAC_W];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign t  = {rp, nb};
    assign ge = (t >= {1'b0, divisor});

    // Subtract where the divisor fits and shift in the quotient bit.
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k]  <= ge ? REM_W'(t - {1'b0, divisor}) : t[REM_W-1:0];
        quo_s[k]  <= {qp[QUO_W-2:0], ge};
        prod_s[k] <= pp;
      end
    end
  end

  assign quo = quo_s[QUO_W];

endmodule

// ===== hdl/brir_blend.sv =====
// Blend pipeline: horizontal blend, vertical blend and rounding into the
// output register, with stall handling. Depends on brir_pkg.

module brir_blend
  import brir_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  blend_req_t          hreq,
  input  logic [31:0]         w00,
  input  logic [31:0]         w01,
  input  logic [31:0]         w10,
  input  logic [31:0]         w11,
  input  logic [CH_CNT_W-1:0] nch,
  output logic                res_valid,
  input  logic                res_stall,
  output res_t                res
);

  logic                h_v;
  logic [TOP_W-1:0]    h_top [0:3];
  logic [TOP_W-1:0]    h_bot [0:3];
  logic [FRAC_W-1:0]   h_wy;
  logic [DCOORD_W-1:0] h_col;
  logic [DCOORD_W-1:0] h_row;

  logic                v_v;
  logic [ACC_W-1:0]    v_acc [0:3];
  logic [DCOORD_W-1:0] v_col;
  logic [DCOORD_W-1:0] v_row;

  logic [TOP_W-1:0]    top_next [0:3];
  logic [TOP_W-1:0]    bot_next [0:3];
  logic [ACC_W-1:0]    acc_next [0:3];
  logic [7:0]          chan_next [0:3];

  logic out_free, v_move, v_free, h_move;

  // Handshake between the stages.
  assign out_free = !res_valid || !res_stall;
  assign v_move   = v_v && out_free;
  assign v_free   = !v_v || out_free;
  assign h_move   = h_v && v_free;

  // Horizontal blend of the top and bottom pixel pairs.
  always_comb begin
    logic [16:0] omx;
    omx = 17'h10000 - {1'b0, hreq.wx};
    for (int c = 0; c < 4; c++) begin
      top_next[c] = TOP_W'(25'(w00[8*c +: 8]) * 25'(omx) + 25'(w01[8*c +: 8]) * 25'(hreq.wx));
      bot_next[c] = TOP_W'(25'(w10[8*c +: 8]) * 25'(omx) + 25'(w11[8*c +: 8]) * 25'(hreq.wx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (hreq.load) begin
      h_v <= 1'b1;
    end else if (h_move) begin
      h_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hreq.load) begin
      h_top <= top_next;
      h_bot <= bot_next;
      h_wy  <= hreq.wy;
      h_col <= hreq.col;
      h_row <= hreq.row;
    end
  end

  // Vertical blend in Q32.
  always_comb begin
    logic [16:0] omy;
    omy = 17'h10000 - {1'b0, h_wy};
    for (int c = 0; c < 4; c++) begin
      acc_next[c] = ACC_W'(h_top[c]) * ACC_W'(omy) + ACC_W'(h_bot[c]) * ACC_W'(h_wy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_v <= 1'b0;
    end else if (h_move) begin
      v_v <= 1'b1;
    end else if (v_move) begin
      v_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (h_move) begin
      v_acc <= acc_next;
      v_col <= h_col;
      v_row <= h_row;
    end
  end

  // Round half up to eight bits; channels beyond the count read zero.
  always_comb begin
    logic [ACC_W-1:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum = v_acc[c] + ACC_W'(32'h8000_0000);
      chan_next[c] = (CH_CNT_W'(c) < nch) ? sum[ACC_W-1:32] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= v_v;
    end
  end

  always_ff @(posedge clk) begin
    if (v_move) begin
      res.res_col   <= v_col;
      res.res_row   <= v_row;
      res.out_chan0 <= chan_next[0];
      res.out_chan1 <= chan_next[1];
      res.out_chan2 <= chan_next[2];
      res.out_chan3 <= chan_next[3];
    end
  end

`ifndef SYNTHESIS
  a_h_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    hreq.load |-> (!h_v || h_move))
    else $error("horizontal stage overwritten");

  a_v_fed_from_h: assert property (@(posedge clk) disable iff (rst)
    (v_v && !$past(v_v)) |-> $past(h_v))
    else $error("vertical stage filled without a horizontal result");

  a_unused_chan: assert property (@(posedge clk) disable iff (rst)
    (res_valid && nch == 3'd1) |-> (res.out_chan1 == 8'd0 && res.out_chan3 == 8'd0))
    else $error("unused channel not zero");
`endif

endmodule

// ===== hdl/bilinear_image_resampler_core.sv =====
// Top level of the bilinear image resampler: configuration registers,
// position divider pipeline, pixel store sequencer and blend pipeline.
// Depends on brir_pkg, brir_ram, brir_div_pipe and brir_blend.

// The block holds a source image in a single-port pixel store of
// MAX_SRC_WIDTH*MAX_SRC_HEIGHT words, one 32-bit word of four 8-bit channels
// per pixel. A request with op 0 loads one source pixel and gives no result;
// one with op 1 asks for one destination pixel and gives exactly one result,
// in request order. Every request first passes a 40-stage pipeline (operand
// setup, 38 divider stages for the half-pixel-center position, neighbour
// mapping), then the store port: a load writes it at once, a pixel read reads
// it once per neighbour in turn. Loads go one per cycle while no pixel read
// holds the port; a read waits for the last one's neighbour reads and for room
// in the blend pipeline, through which its result goes to the output register.
// The store is not cleared at reset: read only pixels that were loaded. Change
// configuration only when the block is idle.

module bilinear_image_resampler_core
  import brir_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Which neighbour a store read fetches.
  localparam logic [1:0] SEL_P00 = 2'd0;
  localparam logic [1:0] SEL_P01 = 2'd1;
  localparam logic [1:0] SEL_P10 = 2'd2;
  localparam logic [1:0] SEL_P11 = 2'd3;

  function automatic logic [AW-1:0] pix_addr(input logic [SIZE_W-1:0] x,
                                              input logic [SIZE_W-1:0] y);
    return AW'(32'(y) * 32'(MAX_SRC_WIDTH) + 32'(x));
  endfunction

  // Configuration registers and their effective values.
  logic [SIZE_W-1:0]   src_width, src_height;
  logic [DSIZE_W-1:0]  dst_width, dst_height;
  logic [CH_CNT_W-1:0] channel_count;
  logic [SIZE_W-1:0]   sw, sh;
  logic [DSIZE_W-1:0]  dw, dh;
  logic [CH_CNT_W-1:0] nch;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= 9'd256;
      src_height    <= 9'd256;
      dst_width     <= 13'd256;
      dst_height    <= 13'd256;
      channel_count <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:     src_width     <= cfg_data[SIZE_W-1:0];
        CFG_SRC_HEIGHT:    src_height    <= cfg_data[SIZE_W-1:0];
        CFG_DST_WIDTH:     dst_width     <= cfg_data;
        CFG_DST_HEIGHT:    dst_height    <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CH_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = (src_width == '0) ? 9'd1 :
         (32'(src_width) > 32'(MAX_SRC_WIDTH)) ? SIZE_W'(MAX_SRC_WIDTH) : src_width;
    sh = (src_height == '0) ? 9'd1 :
         (32'(src_height) > 32'(MAX_SRC_HEIGHT)) ? SIZE_W'(MAX_SRC_HEIGHT) : src_height;
    dw = (dst_width == '0) ? 13'd1 :
         (32'(dst_width) > 32'(DST_MAX)) ? DSIZE_W'(DST_MAX) : dst_width;
    dh = (dst_height == '0) ? 13'd1 :
         (32'(dst_height) > 32'(DST_MAX)) ? DSIZE_W'(DST_MAX) : dst_height;
    nch = (channel_count == '0) ? 3'd1 :
          (32'(channel_count) > 32'(MAX_CHANNELS)) ? CH_CNT_W'(MAX_CHANNELS) : channel_count;
  end

  // Front pipeline: setup stage, divider stages, mapping stage.
  logic              adv, take;
  logic [QUO_W:0]    sv;
  req_t              sitem [0:QUO_W];
  logic [PROD_W-1:0] prodx, prody;
  logic [QUO_W-1:0]  quox, quoy;
  logic              p_v;
  req_t              p_item;
  axis_map_t         p_mx, p_my;

  assign adv       = !p_v || take;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv  <= '0;
      p_v <= 1'b0;
    end else if (adv) begin
      sv  <= {sv[QUO_W-1:0], req_valid};
      p_v <= sv[QUO_W];
    end
  end

  // Setup: (2d+1)*S per axis.
  always_ff @(posedge clk) begin
    if (adv) begin
      sitem[0] <= req;
      prodx    <= PROD_W'({9'b0, req.dst_col, 1'b1}) * PROD_W'(sw);
      prody    <= PROD_W'({9'b0, req.dst_row, 1'b1}) * PROD_W'(sh);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_item
    always_ff @(posedge clk) begin
      if (adv) begin
        sitem[k] <= sitem[k-1];
      end
    end
  end

  brir_div_pipe u_div_x (
    .clk     (clk),
    .adv     (adv),
    .prod    (prodx),
    .divisor ({dw, 1'b0}),
    .quo     (quox)
  );

  brir_div_pipe u_div_y (
    .clk     (clk),
    .adv     (adv),
    .prod    (prody),
    .divisor ({dh, 1'b0}),
    .quo     (quoy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      p_item <= sitem[QUO_W];
      p_mx   <= map_axis(quox, sw);
      p_my   <= map_axis(quoy, sh);
    end
  end

  // Store sequencer: a load writes at once, a read makes four store reads in turn.
  logic                busy;
  logic [1:0]          ph;
  logic [INFL_W-1:0]   inflight;
  logic                is_read, load_ok;
  logic [SIZE_W-1:0]   e_x0, e_x1, e_y0, e_y1;
  logic [FRAC_W-1:0]   e_wx, e_wy;
  logic [DCOORD_W-1:0] e_col, e_row;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [31:0]         ram_wdata, ram_rdata;
  logic                rd_v;
  logic [1:0]          rd_sel;
  logic [31:0]         w00, w01, w10;
  logic                res_take;
  blend_req_t          hreq;

  assign is_read  = (p_item.op == OP_READ);
  assign take     = p_v && !busy && (!is_read || inflight != MAX_INFL);
  assign load_ok  = (32'(p_item.src_col) < 32'(MAX_SRC_WIDTH)) &&
                    (32'(p_item.src_row) < 32'(MAX_SRC_HEIGHT));
  assign res_take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= SEL_P00;
    end else if (take && is_read) begin
      busy <= 1'b1;
      ph   <= SEL_P01;
    end else if (busy) begin
      ph <= ph + 2'd1;
      if (ph == SEL_P11) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_read) begin
      e_x0  <= p_mx.n0;
      e_x1  <= p_mx.n1;
      e_y0  <= p_my.n0;
      e_y1  <= p_my.n1;
      e_wx  <= p_mx.w;
      e_wy  <= p_my.w;
      e_col <= p_item.dst_col;
      e_row <= p_item.dst_row;
    end
  end

  // Requests between store and output, for the blend pipeline's room.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({take && is_read, res_take})
        2'b10:   inflight <= inflight + 2'd1;
        2'b01:   inflight <= inflight - 2'd1;
        default: ;
      endcase
    end
  end

  // Store port address and write selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {p_item.in_chan3, p_item.in_chan2, p_item.in_chan1, p_item.in_chan0};
    ram_addr  = pix_addr(e_x0, e_y0);
    if (take) begin
      if (is_read) begin
        ram_addr = pix_addr(p_mx.n0, p_my.n0);
      end else begin
        ram_we   = load_ok;
        ram_addr = pix_addr({1'b0, p_item.src_col}, {1'b0, p_item.src_row});
      end
    end else if (busy) begin
      case (ph)
        SEL_P01: ram_addr = pix_addr(e_x1, e_y0);
        SEL_P10: ram_addr = pix_addr(e_x0, e_y1);
        SEL_P11: ram_addr = pix_addr(e_x1, e_y1);
        default: ram_addr = pix_addr(e_x0, e_y0);
      endcase
    end
  end

  brir_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Tag the read data that returns in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (take && is_read) || busy;
    end
  end

  always_ff @(posedge clk) begin
    rd_sel <= busy ? ph : SEL_P00;
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      case (rd_sel)
        SEL_P00: w00 <= ram_rdata;
        SEL_P01: w01 <= ram_rdata;
        SEL_P10: w10 <= ram_rdata;
        default: ;
      endcase
    end
  end

  assign hreq = '{load: rd_v && (rd_sel == SEL_P11), wx: e_wx, wy: e_wy,
                  col: e_col, row: e_row};

  brir_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .hreq      (hreq),
    .w00       (w00),
    .w01       (w01),
    .w10       (w10),
    .w11       (ram_rdata),
    .nch       (nch),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_result_has_credit: assert property (@(posedge clk) disable iff (rst)
    res_take |-> (inflight != '0))
    else $error("result delivered with no read request in flight");

  a_no_write_mid_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !busy)
    else $error("store write during a neighbour read sequence");

  a_last_read_in_order: assert property (@(posedge clk) disable iff (rst)
    (rd_v && rd_sel == SEL_P11) |-> ($past(rd_v) && $past(rd_sel) == SEL_P10))
    else $error("fourth neighbour did not follow the third");
`endif

endmodule
